// ----- rtl/assert_macros.svh -----
// Assertion helpers; every user has ports i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/spa_pkg.sv -----
package spa_pkg;

    localparam int NREG       = 4;
    localparam int SIZE_W     = 13;
    localparam int COUNT_W    = 9;
    localparam int REQ_W      = 16;
    localparam int ADDR_W     = 16;
    localparam int BADDR_W    = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int POOL_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_BASE = 3'd4;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  [NREG] = '{13'd16, 13'd32, 13'd64, 13'd128};
    localparam logic [COUNT_W-1:0] COUNT_RESET [NREG] = '{9'd128, 9'd64, 9'd32, 9'd16};

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_INIT  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOSPACE = 3'd1,
        ST_BADSIZE = 3'd2,
        ST_RANGE   = 3'd3,
        ST_DOUBLE  = 3'd4,
        ST_CONFIG  = 3'd5
    } t_status;

    typedef struct packed {
        t_op               op;
        logic [REQ_W-1:0]  req;
        logic [ADDR_W-1:0] addr;
    } t_item;

endpackage

// ----- rtl/segregated_pool_allocator_top.sv -----
// Channel   Direction  Handshake                   Payload
// in        to block   i_in_valid / o_in_ready     i_mode, i_request_size, i_address
// out       from block o_out_valid / i_out_ready   o_block_address, o_status, o_is_free
// cfg       to block   i_cfg_we (no wait)          i_cfg_idx, i_cfg_wdata
//
// Each item first walks the pools with one shared multiplier (multiply, accumulate).
// Alloc then reads the free list; free and query run a 16-step divider and read the
// bitmap; init rebuilds the lists and bitmap, one entry per cycle.
// After reset one pass sets every MAX_BLOCKS bitmap entry free; items wait meanwhile.
// Up to two items wait in a queue while the back end works or the result stalls.
module segregated_pool_allocator_top #(
    parameter int POOLS      = 4,
    parameter int HEAP_BYTES = 8192,
    parameter int MAX_BLOCKS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_mode,
    input  logic [spa_pkg::REQ_W-1:0]     i_request_size,
    input  logic [spa_pkg::ADDR_W-1:0]    i_address,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [spa_pkg::BADDR_W-1:0]   o_block_address,
    output logic [2:0]                    o_status,
    output logic                          o_is_free,
    input  logic                          i_cfg_we,
    input  logic [spa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [spa_pkg::SIZE_W-1:0]    i_cfg_wdata
);
    import spa_pkg::*;

    // pool geometry registers
    logic [SIZE_W-1:0]  r_size  [NREG];
    logic [COUNT_W-1:0] r_count [NREG];

    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    // hold geometry; write sizes below CFG_COUNT_BASE, counts at and above it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SIZE_RESET;
            r_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx < CFG_COUNT_BASE) begin
                r_size[i_cfg_idx[POOL_IDX_W-1:0]] <= i_cfg_wdata;
            end else begin
                r_count[i_cfg_idx[POOL_IDX_W-1:0]] <= i_cfg_wdata[COUNT_W-1:0];
            end
        end
    end

    // front: take and classify requests
    spa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_mode   (i_mode),
        .i_req    (i_request_size),
        .i_addr   (i_address),
        .o_qvalid (q_valid),
        .o_qitem  (q_item),
        .i_qpop   (q_pop)
    );

    // back: run one request at a time against the lists and bitmap
    spa_back #(
        .POOLS      (POOLS),
        .HEAP_BYTES (HEAP_BYTES),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_qvalid        (q_valid),
        .i_qitem         (q_item),
        .o_qpop          (q_pop),
        .i_size          (r_size),
        .i_count         (r_count),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_block_address (o_block_address),
        .o_status        (o_status),
        .o_is_free       (o_is_free)
    );
endmodule

// ----- rtl/spa_ram.sv -----
module spa_ram #(
    parameter int W = 1,
    parameter int D = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/spa_front.sv -----
module spa_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_mode,
    input  logic [spa_pkg::REQ_W-1:0]  i_req,
    input  logic [spa_pkg::ADDR_W-1:0] i_addr,
    output logic                       o_qvalid,
    output spa_pkg::t_item             o_qitem,
    input  logic                       i_qpop
);
    import spa_pkg::*;

    // two-entry queue of classified requests
    t_item      r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_item      item;

    always_comb begin
        item.op   = t_op'(i_mode);
        item.req  = (item.op == OP_ALLOC) ? i_req : '0;
        item.addr = ((item.op == OP_FREE) || (item.op == OP_QUERY)) ? i_addr : '0;
    end

    assign o_ready  = (r_cnt != 2'd2);
    assign push     = i_valid && o_ready;
    assign o_qvalid = (r_cnt != 2'd0);
    assign o_qitem  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_buf[r_wp] <= item;
                r_wp        <= ~r_wp;
            end
            if (i_qpop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_qpop);
        end
    end
endmodule

// ----- rtl/spa_back.sv -----
`include "assert_macros.svh"

module spa_back #(
    parameter int POOLS      = 4,
    parameter int HEAP_BYTES = 8192,
    parameter int MAX_BLOCKS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_qvalid,
    input  spa_pkg::t_item              i_qitem,
    output logic                        o_qpop,
    input  logic [spa_pkg::SIZE_W-1:0]  i_size  [spa_pkg::NREG],
    input  logic [spa_pkg::COUNT_W-1:0] i_count [spa_pkg::NREG],
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [spa_pkg::BADDR_W-1:0] o_block_address,
    output logic [2:0]                  o_status,
    output logic                        o_is_free
);
    import spa_pkg::*;

    localparam int NPOOL = (POOLS < NREG) ? POOLS : NREG;
    localparam int IW    = $clog2(MAX_BLOCKS + 1);
    localparam int AW    = $clog2(MAX_BLOCKS);
    localparam int BW    = 24;
    localparam int TW    = 13;
    localparam int PRW   = SIZE_W + COUNT_W;
    localparam logic [IW-1:0] LINK_END = IW'(MAX_BLOCKS);
    localparam logic [AW-1:0] K_LAST   = AW'(MAX_BLOCKS - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MUL, S_ACC, S_DISPATCH, S_ALLOC_RD, S_ALLOC_FIN,
        S_DIV, S_IDX, S_MAP_RD, S_MAP_FIN, S_SWEEP
    } t_state;

    t_state                r_state;
    t_item                 r_item;
    logic [POOL_IDX_W-1:0] r_pp;
    logic [POOL_IDX_W-1:0] r_p;
    logic [PRW-1:0]        r_prod;
    logic [BW-1:0]         r_sum;
    logic [TW-1:0]         r_total;
    logic                  r_cfgbad;
    logic [BW-1:0]         r_base [NREG];
    logic [BW-1:0]         r_end  [NREG];
    logic                  r_nz   [NREG];
    logic [TW-1:0]         r_pref [NREG];
    logic [TW-1:0]         r_pend [NREG];
    logic [IW-1:0]         r_head [NREG];
    logic [AW-1:0]         r_idx;
    logic [AW-1:0]         r_k;
    logic [13:0]           r_rem;
    logic [ADDR_W-1:0]     r_dq;
    logic [4:0]            r_cnt;
    logic [25:0]           r_aprod;
    logic                  r_ovalid;
    logic [BADDR_W-1:0]    r_baddr;
    t_status               r_status;
    logic                  r_isfree;

    // RAM ports
    logic          link_we;
    logic [AW-1:0] link_wa;
    logic [IW-1:0] link_wd;
    logic [IW-1:0] link_rd;
    logic          map_we;
    logic [AW-1:0] map_wa;
    logic          map_wd;
    logic          map_rd;

    // searches over the pools
    logic                  a_fit;
    logic                  a_found;
    logic [POOL_IDX_W-1:0] a_p;
    logic                  l_found;
    logic [POOL_IDX_W-1:0] l_p;
    logic                  s_found;
    logic [TW-1:0]         s_end;
    logic [IW-1:0]         s_link;
    logic                  req_bad;
    logic                  init_bad;
    logic [13:0]           rem_sh;
    logic                  q_bit;
    logic [16:0]           idx_sum;
    logic [TW-1:0]         diff;

    always_comb begin
        a_fit   = 1'b0;
        a_found = 1'b0;
        a_p     = '0;
        l_found = 1'b0;
        l_p     = '0;
        s_found = 1'b0;
        s_end   = '0;
        for (int p = 0; p < NPOOL; p++) begin
            a_fit = a_fit || ({3'b0, i_size[p]} >= r_item.req);
            if (a_fit && (r_head[p] < LINK_END) && !a_found) begin
                a_found = 1'b1;
                a_p     = POOL_IDX_W'(p);
            end
            if (r_nz[p] && ({8'b0, r_item.addr} < r_end[p]) && !l_found) begin
                l_found = 1'b1;
                l_p     = POOL_IDX_W'(p);
            end
            if ((i_count[p] != '0) && ({{(TW-AW){1'b0}}, r_k} < r_pend[p]) && !s_found) begin
                s_found = 1'b1;
                s_end   = r_pend[p];
            end
        end
        if ({1'b0, r_k} + 1'b1 == IW'(s_end)) begin
            s_link = LINK_END;
        end else begin
            s_link = IW'({1'b0, r_k} + 1'b1);
        end
        req_bad  = (r_item.req == '0) || (r_item.req > {3'b0, i_size[NPOOL-1]});
        init_bad = r_cfgbad || (r_sum != BW'(HEAP_BYTES)) || (r_total > TW'(MAX_BLOCKS));
        rem_sh   = {r_rem[12:0], r_dq[ADDR_W-1]};
        q_bit    = (rem_sh >= {1'b0, i_size[r_p]});
        idx_sum  = {4'b0, r_pref[r_p]} + {1'b0, r_dq};
        diff     = {{(TW-AW){1'b0}}, r_idx} - r_pref[r_p];
    end

    always_comb begin
        link_we = 1'b0;
        link_wa = r_idx;
        link_wd = (r_head[r_p] < LINK_END) ? r_head[r_p] : LINK_END;
        map_we  = 1'b0;
        map_wa  = r_idx;
        map_wd  = 1'b1;
        case (r_state)
            S_CLEAR: begin
                map_we = 1'b1;
                map_wa = r_k;
            end
            S_SWEEP: begin
                map_we  = 1'b1;
                map_wa  = r_k;
                link_we = s_found && ({{(TW-AW){1'b0}}, r_k} < r_total);
                link_wa = r_k;
                link_wd = s_link;
            end
            S_ALLOC_RD: begin
                map_we = 1'b1;
                map_wd = 1'b0;
            end
            S_MAP_FIN: begin
                if ((r_item.op == OP_FREE) && !map_rd) begin
                    map_we  = 1'b1;
                    link_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    spa_ram #(.W(IW), .D(MAX_BLOCKS)) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_wa),
        .i_wdata (link_wd),
        .i_raddr (r_idx),
        .o_rdata (link_rd)
    );

    spa_ram #(.W(1), .D(MAX_BLOCKS)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_wa),
        .i_wdata (map_wd),
        .i_raddr (r_idx),
        .o_rdata (map_rd)
    );

    assign o_qpop = (r_state == S_IDLE) && i_qvalid && !r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_k      <= '0;
            r_ovalid <= 1'b0;
            for (int p = 0; p < NREG; p++) begin
                r_head[p] <= LINK_END;
            end
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == K_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_qpop) begin
                        r_item   <= i_qitem;
                        r_pp     <= '0;
                        r_sum    <= '0;
                        r_total  <= '0;
                        r_cfgbad <= 1'b0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PRW'(i_size[r_pp]) * PRW'(i_count[r_pp]);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_base[r_pp] <= r_sum;
                    r_end[r_pp]  <= r_sum + BW'(r_prod);
                    r_nz[r_pp]   <= (r_prod != '0);
                    r_pref[r_pp] <= r_total;
                    r_pend[r_pp] <= r_total + TW'(i_count[r_pp]);
                    r_sum        <= r_sum + BW'(r_prod);
                    r_total      <= r_total + TW'(i_count[r_pp]);
                    if ((i_size[r_pp] == '0) && (i_count[r_pp] != '0)) begin
                        r_cfgbad <= 1'b1;
                    end
                    if (r_pp == POOL_IDX_W'(NPOOL - 1)) begin
                        r_state <= S_DISPATCH;
                    end else begin
                        r_pp    <= r_pp + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_DISPATCH: begin
                    r_baddr  <= '0;
                    r_isfree <= 1'b0;
                    case (r_item.op)
                        OP_ALLOC: begin
                            if (req_bad) begin
                                r_status <= ST_BADSIZE;
                                r_ovalid <= 1'b1;
                                r_state  <= S_IDLE;
                            end else if (!a_found) begin
                                r_status <= ST_NOSPACE;
                                r_ovalid <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_p     <= a_p;
                                r_idx   <= r_head[a_p][AW-1:0];
                                r_state <= S_ALLOC_RD;
                            end
                        end
                        OP_INIT: begin
                            if (init_bad) begin
                                r_status <= ST_CONFIG;
                                r_ovalid <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                for (int p = 0; p < NPOOL; p++) begin
                                    r_head[p] <= (i_count[p] == '0) ? LINK_END
                                                                    : IW'(r_pref[p]);
                                end
                                r_k     <= '0;
                                r_state <= S_SWEEP;
                            end
                        end
                        default: begin
                            if (({1'b0, r_item.addr} >= 17'(HEAP_BYTES)) || !l_found) begin
                                r_status <= ST_RANGE;
                                r_ovalid <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_p     <= l_p;
                                r_dq    <= r_item.addr - r_base[l_p][ADDR_W-1:0];
                                r_rem   <= '0;
                                r_cnt   <= '0;
                                r_state <= S_DIV;
                            end
                        end
                    endcase
                end
                S_ALLOC_RD: begin
                    r_aprod <= 26'(diff) * 26'(i_size[r_p]);
                    r_state <= S_ALLOC_FIN;
                end
                S_ALLOC_FIN: begin
                    r_head[r_p] <= link_rd;
                    r_baddr     <= r_base[r_p][BADDR_W-1:0] + r_aprod[BADDR_W-1:0];
                    r_status    <= ST_OK;
                    r_ovalid    <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_DIV: begin
                    r_rem <= q_bit ? (rem_sh - {1'b0, i_size[r_p]}) : rem_sh;
                    r_dq  <= {r_dq[ADDR_W-2:0], q_bit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'(ADDR_W - 1)) begin
                        r_state <= S_IDX;
                    end
                end
                S_IDX: begin
                    if (idx_sum >= 17'(MAX_BLOCKS)) begin
                        r_status <= ST_RANGE;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx   <= idx_sum[AW-1:0];
                        r_state <= S_MAP_RD;
                    end
                end
                S_MAP_RD: begin
                    r_state <= S_MAP_FIN;
                end
                S_MAP_FIN: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                    if (r_item.op == OP_QUERY) begin
                        r_status <= ST_OK;
                        r_isfree <= map_rd;
                    end else if (map_rd) begin
                        r_status <= ST_DOUBLE;
                    end else begin
                        r_status    <= ST_OK;
                        r_head[r_p] <= IW'(r_idx);
                    end
                end
                S_SWEEP: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == K_LAST) begin
                        r_status <= ST_OK;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_block_address = r_baddr;
    assign o_status        = r_status;
    assign o_is_free       = r_isfree;

    `ASSERT_IMP(a_start_when_empty, o_qpop, !r_ovalid)
    `ASSERT_NXT(a_single_pop, o_qpop, !o_qpop)
    `ASSERT_IMP(a_addr_only_ok, r_ovalid && (r_status != ST_OK), r_baddr == '0)
    `ASSERT_IMP(a_free_only_ok, r_ovalid && r_isfree, r_status == ST_OK)
endmodule

// ----- test/segregated_pool_allocator_top_test.sv -----
`timescale 1ns / 1ps

module segregated_pool_allocator_top_test;
    import spa_pkg::*;

    localparam int HEAP  = 8192;
    localparam int NBLK  = 256;
    localparam int LEND  = NBLK;

    typedef struct {
        logic [BADDR_W-1:0] baddr;
        t_status            status;
        logic               is_free;
    } t_heap_reply;

    typedef struct {
        logic [SIZE_W-1:0]  sz [NREG];
        logic [COUNT_W-1:0] ct [NREG];
    } t_layout;

    // Scoreboard: own copy of the pool layout, free lists and bitmap.
    class pool_heap_scoreboard;
        logic [SIZE_W-1:0]  blk_size [NREG];
        logic [COUNT_W-1:0] blk_count [NREG];
        int unsigned        list_head [NREG];
        int unsigned        next_blk [NBLK];
        bit                 blk_free [NBLK];
        t_heap_reply        replies_due [$];
        int                 errors;
        int                 status_seen [8];
        int                 checked;

        function new();
            for (int p = 0; p < NREG; p++) begin
                blk_size[p]  = SIZE_RESET[p];
                blk_count[p] = COUNT_RESET[p];
                list_head[p] = LEND;
            end
            for (int i = 0; i < NBLK; i++) begin
                next_blk[i] = 0;
                blk_free[i] = 1;
            end
            errors  = 0;
            checked = 0;
        endfunction

        function void write_reg(int idx, logic [SIZE_W-1:0] v);
            if (idx < NREG) blk_size[idx] = v;
            else blk_count[idx - NREG] = v[COUNT_W-1:0];
        endfunction

        function bit block_of(int unsigned a, output int unsigned idx);
            longint unsigned base, bytes;
            int unsigned prefix;
            base   = 0;
            prefix = 0;
            idx    = 0;
            if (a >= HEAP) return 0;
            for (int p = 0; p < NREG; p++) begin
                bytes = longint'(blk_size[p]) * blk_count[p];
                if (bytes != 0 && a < base + bytes) begin
                    idx = prefix + int'((a - base) / blk_size[p]);
                    return idx < NBLK;
                end
                base   += bytes;
                prefix += blk_count[p];
            end
            return 0;
        endfunction

        function t_status rebuild_lists();
            longint unsigned sum;
            int unsigned total, prefix;
            sum   = 0;
            total = 0;
            prefix = 0;
            for (int p = 0; p < NREG; p++) begin
                sum   += longint'(blk_size[p]) * blk_count[p];
                total += blk_count[p];
                if (blk_size[p] == 0 && blk_count[p] != 0) return ST_CONFIG;
            end
            if (sum != HEAP || total > NBLK) return ST_CONFIG;
            for (int p = 0; p < NREG; p++) begin
                if (blk_count[p] == 0) begin
                    list_head[p] = LEND;
                    continue;
                end
                list_head[p] = prefix;
                for (int k = 0; k < blk_count[p]; k++)
                    next_blk[prefix + k] = (k + 1 < blk_count[p]) ? prefix + k + 1 : LEND;
                prefix += blk_count[p];
            end
            for (int i = 0; i < NBLK; i++) blk_free[i] = 1;
            return ST_OK;
        endfunction

        function t_status take_block(int unsigned req, output logic [BADDR_W-1:0] a);
            int p;
            int unsigned idx, prefix;
            longint unsigned base;
            a = '0;
            if (req == 0 || req > blk_size[NREG-1]) return ST_BADSIZE;
            p = 0;
            while (p < NREG && req > blk_size[p]) p++;
            while (p < NREG && list_head[p] >= NBLK) p++;
            if (p >= NREG) return ST_NOSPACE;
            idx = list_head[p];
            list_head[p] = next_blk[idx];
            blk_free[idx] = 0;
            base   = 0;
            prefix = 0;
            for (int q = 0; q < p; q++) begin
                base   += longint'(blk_size[q]) * blk_count[q];
                prefix += blk_count[q];
            end
            a = BADDR_W'(base + longint'(idx - prefix) * blk_size[p]);
            return ST_OK;
        endfunction

        // Note an accepted request; return what the block must answer.
        function t_heap_reply note_request(t_op op, logic [REQ_W-1:0] req,
                                           logic [ADDR_W-1:0] addr);
            t_heap_reply r;
            int unsigned idx, prefix;
            int p;
            r.baddr   = '0;
            r.status  = ST_OK;
            r.is_free = 1'b0;
            if (op == OP_ALLOC) begin
                r.status = take_block(req, r.baddr);
            end else if (op == OP_INIT) begin
                r.status = rebuild_lists();
            end else if (!block_of(addr, idx)) begin
                r.status = ST_RANGE;
            end else if (op == OP_QUERY) begin
                r.is_free = blk_free[idx];
            end else if (blk_free[idx]) begin
                r.status = ST_DOUBLE;
            end else begin
                prefix = 0;
                for (p = 0; p < NREG; p++) begin
                    if (idx < prefix + blk_count[p]) break;
                    prefix += blk_count[p];
                end
                if (p >= NREG) p = NREG - 1;
                next_blk[idx] = (list_head[p] < NBLK) ? list_head[p] : LEND;
                list_head[p]  = idx;
                blk_free[idx] = 1;
            end
            replies_due.push_back(r);
            return r;
        endfunction

        function void check_result(logic [BADDR_W-1:0] baddr, logic [2:0] status,
                                   logic is_free);
            t_heap_reply e;
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected result addr=%0d status=%0d free=%0d",
                         $realtime, baddr, status, is_free);
                errors++;
                return;
            end
            e = replies_due.pop_front();
            checked++;
            status_seen[status]++;
            if (baddr !== e.baddr) begin
                $display("%0t: block_address expected %0d actual %0d", $realtime, e.baddr, baddr);
                errors++;
            end
            if (status !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $realtime, e.status, status);
                errors++;
            end
            if (is_free !== e.is_free) begin
                $display("%0t: is_free expected %0d actual %0d", $realtime, e.is_free, is_free);
                errors++;
            end
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_mode;
    logic [REQ_W-1:0]     i_request_size;
    logic [ADDR_W-1:0]    i_address;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [BADDR_W-1:0]   o_block_address;
    logic [2:0]           o_status;
    logic                 o_is_free;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [SIZE_W-1:0]    i_cfg_wdata;

    segregated_pool_allocator_top dut (.*);

    pool_heap_scoreboard sb = new();

    bit   calm;        // no idling on either side while set
    bit   hold_req;    // ask the receiver for one long hold-off
    int   items_sent;
    int   layouts_run;
    logic [BADDR_W-1:0] held [$];   // blocks currently owned by the test
    logic [SIZE_W-1:0]  top_size;   // largest allowed request of the live layout

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    initial begin
        #2_000_000;
        $display("segregated_pool_allocator_top_test: errors");
        $finish;
    end

    // Receiver: check on accept, then pick ready for the next cycle.
    initial begin
        int hold_left;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_block_address, o_status, o_is_free);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 0;
                hold_left = 400;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    // Offer one item and hold it until accepted.
    task automatic send(t_op op, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr);
        t_heap_reply r;
        if (!calm && $urandom_range(0, 99) < 33) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= op;
        i_request_size <= req;
        i_address      <= addr;
        do @(posedge i_clk); while (!o_in_ready);
        r = sb.note_request(op, req, addr);
        items_sent++;
        // keep what we own so later frees hit real blocks
        if (op == OP_ALLOC && r.status == ST_OK) held.push_back(r.baddr);
        if (op == OP_INIT && r.status == ST_OK) held.delete();
    endtask

    // Drain, let the back end settle, then write all eight registers.
    task automatic load_layout(t_layout l);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        for (int i = 0; i < 2 * NREG; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= CFG_IDX_W'(i);
            i_cfg_wdata <= (i < NREG) ? l.sz[i] : SIZE_W'(l.ct[i - NREG]);
            @(posedge i_clk);
            sb.write_reg(i, (i < NREG) ? l.sz[i] : SIZE_W'(l.ct[i - NREG]));
        end
        i_cfg_we <= 1'b0;
        top_size = l.sz[NREG-1];
        layouts_run++;
    endtask

    function automatic t_layout make_layout(int s0, int s1, int s2, int s3,
                                            int c0, int c1, int c2, int c3);
        t_layout l;
        l.sz = '{SIZE_W'(s0), SIZE_W'(s1), SIZE_W'(s2), SIZE_W'(s3)};
        l.ct = '{COUNT_W'(c0), COUNT_W'(c1), COUNT_W'(c2), COUNT_W'(c3)};
        return l;
    endfunction

    // Random layout that fills the heap exactly within the block budget.
    function automatic t_layout random_layout();
        t_layout l;
        int used, tot, rem;
        forever begin
            used = 0;
            tot  = 0;
            for (int p = 0; p < NREG - 1; p++) begin
                l.sz[p] = SIZE_W'($urandom_range(1, 64));
                l.ct[p] = COUNT_W'($urandom_range(0, 48));
                used += l.sz[p] * l.ct[p];
                tot  += l.ct[p];
            end
            rem = HEAP - used;
            if (rem <= 0) continue;
            for (int c = NBLK - tot; c >= 1; c--) begin
                if (rem % c == 0 && rem / c <= 4096) begin
                    l.ct[NREG-1] = COUNT_W'(c);
                    l.sz[NREG-1] = SIZE_W'(rem / c);
                    return l;
                end
            end
        end
    endfunction

    // Mostly alloc/free traffic on owned blocks, plus queries and noise.
    task automatic random_traffic(int n);
        int k, pick;
        logic [REQ_W-1:0] req;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 40) begin
                req = ($urandom_range(0, 9) == 0) ? REQ_W'($urandom())
                                                  : REQ_W'($urandom_range(1, top_size));
                send(OP_ALLOC, req, ADDR_W'($urandom()));
            end else if (k < 72 && held.size() > 0) begin
                pick = $urandom_range(0, held.size() - 1);
                send(OP_FREE, REQ_W'($urandom()), held[pick]);
                held.delete(pick);
            end else if (k < 80) begin
                send(OP_FREE, REQ_W'($urandom()), ADDR_W'($urandom_range(0, HEAP - 1)));
            end else if (k < 90 && held.size() > 0) begin
                send(OP_QUERY, REQ_W'($urandom()), held[$urandom_range(0, held.size() - 1)]);
            end else if (k < 98) begin
                send(OP_QUERY, REQ_W'($urandom()),
                     ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom())
                                                 : ADDR_W'($urandom_range(0, HEAP - 1)));
            end else begin
                send(OP_INIT, REQ_W'($urandom()), ADDR_W'($urandom()));
            end
        end
    endtask

    initial begin
        t_layout l;
        calm           = 0;
        hold_req       = 0;
        items_sent     = 0;
        layouts_run    = 0;
        top_size       = SIZE_RESET[NREG-1];
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_mode         = OP_ALLOC;
        i_request_size = '0;
        i_address      = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_wdata    = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Before any init: no space on alloc, already free on free.
        send(OP_ALLOC, 16'd1, 16'd0);
        send(OP_FREE, 16'd0, 16'd0);
        send(OP_QUERY, 16'd0, 16'd100);
        send(OP_INIT, 16'hFFFF, 16'hFFFF);
        send(OP_ALLOC, 16'd0, 16'd0);        // zero size
        send(OP_ALLOC, 16'd129, 16'd0);      // above the largest pool
        send(OP_ALLOC, 16'hFFFF, 16'd0);
        send(OP_ALLOC, 16'd1, 16'd0);
        send(OP_ALLOC, 16'd16, 16'd0);
        send(OP_ALLOC, 16'd17, 16'd0);
        send(OP_ALLOC, 16'd128, 16'd0);
        send(OP_QUERY, 16'd0, 16'd5);        // inside an owned block
        send(OP_FREE, 16'd0, 16'd7);         // free by interior address
        send(OP_FREE, 16'd0, 16'd0);         // double free
        send(OP_QUERY, 16'd0, 16'd8191);
        send(OP_QUERY, 16'd0, 16'd8192);     // past the heap
        send(OP_FREE, 16'd0, 16'hFFFF);
        send(OP_FREE, 16'd0, 16'd6144);      // last pool, allocated above

        // Extreme layouts, including ones that fail init.
        load_layout(make_layout(1, 1, 1, 4096, 0, 0, 0, 2));
        send(OP_INIT, 16'd0, 16'd0);
        random_traffic(30);                  // spills and exhaustion
        load_layout(make_layout(32, 1, 1, 1, 256, 0, 0, 0));
        send(OP_INIT, 16'd0, 16'd0);
        random_traffic(40);
        load_layout(make_layout(1, 1, 4094, 4096, 1, 1, 1, 1));
        send(OP_INIT, 16'd0, 16'd0);
        random_traffic(30);
        load_layout(make_layout(16, 32, 64, 128, 255, 64, 32, 16));   // too many blocks
        send(OP_INIT, 16'd0, 16'd0);
        random_traffic(15);
        load_layout(make_layout(0, 32, 64, 128, 10, 64, 32, 16));     // zero-size pool
        send(OP_INIT, 16'd0, 16'd0);
        load_layout(make_layout(16, 32, 64, 100, 128, 64, 32, 16));   // short of the heap
        send(OP_INIT, 16'd0, 16'd0);
        random_traffic(15);

        // Pressure: receiver holds off while requests keep coming.
        load_layout(make_layout(16, 32, 64, 128, 128, 64, 32, 16));
        send(OP_INIT, 16'd0, 16'd0);
        hold_req = 1;
        random_traffic(40);

        // Stretch with no idling at all.
        calm = 1;
        random_traffic(100);
        calm = 0;

        while (items_sent < 1150) begin
            load_layout(random_layout());
            send(OP_INIT, 16'd0, 16'd0);
            random_traffic(80);
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("covered %0d requests over %0d layouts, %0d results checked",
                 items_sent, layouts_run, sb.checked);
        $display("statuses ok/nospace/badsize/range/double/config: %0d/%0d/%0d/%0d/%0d/%0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], sb.status_seen[4], sb.status_seen[5]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("segregated_pool_allocator_top_test: clean");
        end else begin
            $display("segregated_pool_allocator_top_test: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/spa_pkg.sv
rtl/spa_ram.sv
rtl/spa_front.sv
rtl/spa_back.sv
rtl/segregated_pool_allocator_top.sv
test/segregated_pool_allocator_top_test.sv
